FILE: hdl/assert_macros.svh
// assertion macros shared by the list block
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define APLL_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("list block check failed");

// next-cycle implication, off during reset
`define APLL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("list block check failed");

`endif

FILE: hdl/apll_pkg.sv
// types, constants and codes for the pooled linked list block
// no dependencies
package apll_pkg;

    localparam int POOL_SIZE = 16;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SIZE);

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD   = 3'd0,
        OP_INS_TAIL   = 3'd1,
        OP_INS_SORTED = 3'd2,
        OP_DEL_FIRST  = 3'd3,
        OP_DEL_ALL    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_WALK,
        S_LINK,
        S_DEL_WALK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic alloc;
        logic mark_full;
        logic ins_step;
        logic link;
        logic del_unlink;
        logic del_skip;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op_ins;
        logic op_head;
        logic op_del;
        logic op_first;
        logic free_empty;
        logic ins_go;
        logic del_end;
        logic del_hit;
        logic out_free;
    } t_stat;

endpackage

FILE: hdl/apll_in_if.sv
// input channel of the list block: operation and value
// depends on apll_pkg
interface apll_in_if;
    import apll_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

FILE: hdl/apll_out_if.sv
// result channel of the list block: status, removed count, length
// depends on apll_pkg
interface apll_out_if;
    import apll_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  removed_count;
    logic [COUNT_W-1:0]  list_length;

    modport source (output valid, output status, output removed_count,
                    output list_length, input ready);
    modport sink (input valid, input status, input removed_count,
                  input list_length, output ready);
endinterface

FILE: hdl/array_pool_linked_list_top.sv
// top level of the pooled singly linked list with free list
// depends on apll_pkg, apll_in_if, apll_out_if, apll_ctrl, apll_dp
// sequence: an accepted item is dispatched; an insert at head then links the new node, tail and
//   sorted inserts walk one node per step before linking, deletes walk and unlink matches (delete
//   first stops at its first match); a full pool or an unused code goes straight to finish
// the result loads once the output register is free; the next item is taken in the cycle after it loads
// a new item is taken while the previous result still waits in the output register
// reset: list empty, free chain rebuilt as node i -> node i-1, node values undefined
module array_pool_linked_list_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apll_in_if.sink   i_in,
    apll_out_if.source o_out
);
    import apll_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: dispatch, walk, link and result handoff
    apll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // node pool, heads, counters and the result register
    apll_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_in.operation),
        .i_value         (i_in.value),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_status        (o_out.status),
        .o_removed_count (o_out.removed_count),
        .o_list_length   (o_out.list_length)
    );

endmodule

FILE: hdl/apll_ctrl.sv
// controller state machine of the list block
// depends on apll_pkg
module apll_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  apll_pkg::t_stat i_stat,
    output apll_pkg::t_cmd  o_cmd
);
    import apll_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op_ins) begin
                    if (i_stat.free_empty) begin
                        o_cmd.mark_full = 1'b1;
                        n_state         = S_FINISH;
                    end else begin
                        o_cmd.alloc = 1'b1;
                        n_state     = i_stat.op_head ? S_LINK : S_INS_WALK;
                    end
                end else if (i_stat.op_del) begin
                    n_state = S_DEL_WALK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_INS_WALK: begin
                if (i_stat.ins_go) begin
                    o_cmd.ins_step = 1'b1;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_FINISH;
            end
            S_DEL_WALK: begin
                if (i_stat.del_end) begin
                    n_state = S_FINISH;
                end else if (i_stat.del_hit) begin
                    o_cmd.del_unlink = 1'b1;
                    if (i_stat.op_first) begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_cmd.del_skip = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/apll_dp.sv
// datapath of the list block: node pool, list and free heads, result register
// depends on apll_pkg and assert_macros.svh
module apll_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  apll_pkg::t_cmd                     i_cmd,
    output apll_pkg::t_stat                    o_stat,
    input  logic [apll_pkg::OP_W-1:0]          i_operation,
    input  logic signed [apll_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [apll_pkg::STATUS_W-1:0]      o_status,
    output logic [apll_pkg::COUNT_W-1:0]       o_removed_count,
    output logic [apll_pkg::COUNT_W-1:0]       o_list_length
);
    import apll_pkg::*;
    `include "assert_macros.svh"

    logic signed [VALUE_W-1:0] r_value [POOL_SIZE];
    logic [LINK_W-1:0]         r_link  [POOL_SIZE];

    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_val;
    logic [LINK_W-1:0]         r_list_head;
    logic [LINK_W-1:0]         r_free_head;
    logic [LINK_W-1:0]         r_count;
    logic [LINK_W-1:0]         r_cur;
    logic [LINK_W-1:0]         r_prev;
    logic [LINK_W-1:0]         r_new;
    logic [LINK_W-1:0]         r_steps;
    logic [LINK_W-1:0]         r_removed;
    logic                      r_full;

    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_out_status;
    logic [COUNT_W-1:0]        r_out_removed;
    logic [COUNT_W-1:0]        r_out_length;

    logic [IDX_W-1:0]          cur_idx;
    logic [IDX_W-1:0]          prev_idx;
    logic [IDX_W-1:0]          rd_idx;
    logic [LINK_W-1:0]         rd_link;
    logic signed [VALUE_W-1:0] cur_value;
    logic                      cur_is_node;
    logic                      prev_is_node;
    logic                      steps_done;
    logic                      is_del;
    logic [STATUS_W-1:0]       n_status;

    assign cur_idx      = r_cur[IDX_W-1:0];
    assign prev_idx     = r_prev[IDX_W-1:0];
    // one link read port: free head during allocation, walk cursor otherwise
    assign rd_idx       = i_cmd.alloc ? r_free_head[IDX_W-1:0] : cur_idx;
    assign rd_link      = r_link[rd_idx];
    assign cur_value    = r_value[cur_idx];
    assign cur_is_node  = (r_cur < LINK_W'(POOL_SIZE));
    assign prev_is_node = (r_prev < LINK_W'(POOL_SIZE));
    assign steps_done   = (r_steps == LINK_W'(POOL_SIZE));
    assign is_del       = (r_op == OP_DEL_FIRST) || (r_op == OP_DEL_ALL);

    always_comb begin
        o_stat            = '0;
        o_stat.op_ins     = (r_op == OP_INS_HEAD) || (r_op == OP_INS_TAIL)
                            || (r_op == OP_INS_SORTED);
        o_stat.op_head    = (r_op == OP_INS_HEAD);
        o_stat.op_del     = is_del;
        o_stat.op_first   = (r_op == OP_DEL_FIRST);
        o_stat.free_empty = (r_free_head == LINK_NULL);
        o_stat.ins_go     = cur_is_node && !steps_done
                            && ((r_op == OP_INS_TAIL) || (cur_value < r_val));
        o_stat.del_end    = !cur_is_node || steps_done;
        o_stat.del_hit    = (cur_value == r_val);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        if (r_full) begin
            n_status = ST_FULL;
        end else if (is_del && (r_removed == '0)) begin
            n_status = ST_NO_MATCH;
        end else begin
            n_status = ST_DONE;
        end
    end

    // node values: written on allocation only
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_value[r_free_head[IDX_W-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_link[i] <= (i == 0) ? LINK_NULL : LINK_W'(i - 1);
            end
            r_list_head <= LINK_NULL;
            r_free_head <= LINK_W'(POOL_SIZE - 1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_full <= 1'b0;
            end
            if (i_cmd.mark_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.alloc) begin
                r_free_head <= rd_link;
            end
            if (i_cmd.link) begin
                r_link[r_new[IDX_W-1:0]] <= r_cur;
                if (prev_is_node) begin
                    r_link[prev_idx] <= r_new;
                end else begin
                    r_list_head <= r_new;
                end
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.del_unlink) begin
                if (prev_is_node) begin
                    r_link[prev_idx] <= rd_link;
                end else begin
                    r_list_head <= rd_link;
                end
                r_link[cur_idx] <= r_free_head;
                r_free_head     <= r_cur;
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_val     <= i_value;
            r_cur     <= r_list_head;
            r_prev    <= LINK_NULL;
            r_steps   <= '0;
            r_removed <= '0;
        end
        if (i_cmd.alloc) begin
            r_new <= r_free_head;
        end
        if (i_cmd.ins_step || i_cmd.del_skip) begin
            r_prev  <= r_cur;
            r_cur   <= rd_link;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.del_unlink) begin
            r_cur     <= rd_link;
            r_steps   <= r_steps + 1'b1;
            r_removed <= r_removed + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_status  <= n_status;
            r_out_removed <= COUNT_W'(r_removed);
            r_out_length  <= COUNT_W'(r_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_count = r_out_removed;
    assign o_list_length   = r_out_length;

    // free chain empties at allocation, the count catches up at link
    `APLL_ASSERT_NOW(a_empty_pool_full, i_clk, i_rst_n, r_free_head == LINK_NULL,
                     r_count >= LINK_W'(POOL_SIZE - 1))
    `APLL_ASSERT_NOW(a_no_head_empty, i_clk, i_rst_n, r_list_head == LINK_NULL, r_count == '0)
    `APLL_ASSERT_NEXT(a_link_grows, i_clk, i_rst_n, i_cmd.link, r_count == $past(r_count) + 1'b1)
    `APLL_ASSERT_NEXT(a_unlink_frees, i_clk, i_rst_n, i_cmd.del_unlink, r_free_head == $past(r_cur))

endmodule
